/* sv/clkpm_pkg.sv */
// Package for the clock and power manager register block.
// Holds register slots, transfer kinds, error codes, reset values and the sequencer states.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package clkpm_pkg;

   // Register file geometry.
   localparam int RegCount     = 6;
   localparam int SlotWidth    = 3;
   localparam int DataWidth    = 32;
   localparam int OffsetWidth  = 20;
   localparam int FinWidth     = 26;
   localparam int RateWidth    = 34;
   localparam int ProdWidth    = 35;
   localparam int DivisorWidth = 10;
   localparam int CountWidth   = 6;

   // Reset values of the input clock frequency register and of the derived rates.
   localparam logic [FinWidth-1:0]  InputClockReset = 26'd12000000;
   localparam logic [RateWidth-1:0] RateReset       = 34'd12000000;

   // Register slots.
   localparam logic [SlotWidth-1:0] SlotLocktime = 3'd0;
   localparam logic [SlotWidth-1:0] SlotMpllcon  = 3'd1;
   localparam logic [SlotWidth-1:0] SlotUpllcon  = 3'd2;
   localparam logic [SlotWidth-1:0] SlotClkcon   = 3'd3;
   localparam logic [SlotWidth-1:0] SlotClkslow  = 3'd4;
   localparam logic [SlotWidth-1:0] SlotClkdivn  = 3'd5;

   // Kinds of request transfer.
   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_WRITE   = 2'd1,
      KIND_RESET   = 2'd2,
      KIND_REFRESH = 2'd3
   } kind_type;

   // Error codes reported with each response.
   typedef enum logic [2:0] {
      ERR_OK          = 3'd0,
      ERR_BAD_OFFSET  = 3'd1,
      ERR_UNMODELED   = 3'd2,
      ERR_MPLL_OFF    = 3'd3,
      ERR_UCLK_OFF    = 3'd4,
      ERR_IDLE_POWER  = 3'd5,
      ERR_SPECIAL     = 3'd6,
      ERR_GATES       = 3'd7
   } err_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_RATES,
      ST_REPLY
   } state_type;

   // Register bit fields and masks.
   localparam logic [DataWidth-1:0] ClkconGateMask = 32'h0007_FEF0;
   localparam int SlowModeBit   = 4;
   localparam int SlowMpllOff   = 5;
   localparam int SlowUclkOn    = 7;
   localparam int ClkconSpecial = 0;
   localparam int ClkconIdle    = 2;
   localparam int ClkconPwrOff  = 3;
   localparam int ClkconPwm     = 8;

   // Reset value of each register slot.
   function automatic logic [DataWidth-1:0] reg_reset(input logic [SlotWidth-1:0] slot);
      logic [DataWidth-1:0] val;
      unique case (slot)
         SlotLocktime: val = 32'h00FF_FFFF;
         SlotMpllcon:  val = 32'h0005_C080;
         SlotUpllcon:  val = 32'h0002_8080;
         SlotClkcon:   val = 32'h0007_FFF0;
         SlotClkslow:  val = 32'h0000_0004;
         default:      val = 32'h0000_0000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* sv/clkpm_channels.sv */
// Handshake channels of the clock and power manager: request, response and configuration.
// Each carries valid, ready and its payload; depends on clkpm_pkg for field widths.
`default_nettype none

interface clkpm_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          kind;
   logic [clkpm_pkg::OffsetWidth-1:0]   byte_offset;
   logic [clkpm_pkg::DataWidth-1:0]     write_data;
   logic [1:0]                          bus_mode_bits;

   modport source (output valid, kind, byte_offset, write_data, bus_mode_bits, input ready);
   modport sink   (input valid, kind, byte_offset, write_data, bus_mode_bits, output ready);
endinterface

interface clkpm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [clkpm_pkg::DataWidth-1:0]   read_data;
   logic [clkpm_pkg::RateWidth-1:0]   fast_clock_hz;
   logic [clkpm_pkg::RateWidth-1:0]   bus_clock_hz;
   logic [clkpm_pkg::RateWidth-1:0]   periph_clock_hz;
   logic [clkpm_pkg::RateWidth-1:0]   core_clock_hz;
   logic                              pwm_clock_on;
   logic [2:0]                        error_code;
   logic                              rates_changed;
   logic                              idle_request;
   logic                              sleep_request;

   modport source (output valid, read_data, fast_clock_hz, bus_clock_hz, periph_clock_hz,
                   core_clock_hz, pwm_clock_on, error_code, rates_changed, idle_request,
                   sleep_request, input ready);
   modport sink   (input valid, read_data, fast_clock_hz, bus_clock_hz, periph_clock_hz,
                   core_clock_hz, pwm_clock_on, error_code, rates_changed, idle_request,
                   sleep_request, output ready);
endinterface

interface clkpm_csr_if;
   logic                             valid;
   logic                             ready;
   logic [clkpm_pkg::FinWidth-1:0]   input_clock_hz;

   modport source (output valid, input_clock_hz, input ready);
   modport sink   (input valid, input_clock_hz, output ready);
endinterface

`default_nettype wire

/* sv/clock_power_manager_registers_core.sv */
// Clock and power manager register block: six registers, derived FCLK/HCLK/PCLK rates.
// A retuning transfer passes through the load state, the shared restoring divider (one
// quotient bit per cycle over a 35-bit dividend) and the rate state before it replies;
// reads, plain writes and rejected writes go straight to the reply state.
// A new request waits until the last response is loaded; a stalled output delays that.
// Synchronous active-high reset restores register and rate reset values and empties the output.
`default_nettype none

module clock_power_manager_registers_core (
   input  wire logic  clock,
   input  wire logic  reset,
   clkpm_req_if.sink  req_ch,
   clkpm_rsp_if.source rsp_ch,
   clkpm_csr_if.sink  csr_ch
);
   import clkpm_pkg::*;

   // Architectural state.
   logic [DataWidth-1:0]    regs_ff [RegCount];
   logic [DataWidth-1:0]    regs_in [RegCount];
   logic                    pll_set_ff, pll_set_in;
   logic [FinWidth-1:0]     fin_ff;
   logic [RateWidth-1:0]    fclk_ff, fclk_in;
   logic [RateWidth-1:0]    hclk_ff, hclk_in;
   logic [RateWidth-1:0]    pclk_ff, pclk_in;

   // Sequencer and per-transfer results.
   state_type               state_ff, state_in;
   logic [DataWidth-1:0]    rd_ff, rd_in;
   err_type                 err_ff, err_in;
   logic                    chg_ff, chg_in;
   logic                    idle_ff, idle_in;
   logic                    sleep_ff, sleep_in;
   logic [1:0]              mode_ff, mode_in;

   // Shared divider.
   logic [ProdWidth-1:0]    quo_ff, quo_in;
   logic [DivisorWidth-1:0] rem_ff, rem_in;
   logic [DivisorWidth-1:0] dvs_ff, dvs_in;
   logic [CountWidth-1:0]   cnt_ff, cnt_in;

   // Response output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]    o_rd_ff, o_rd_in;
   logic [RateWidth-1:0]    o_fclk_ff, o_fclk_in;
   logic [RateWidth-1:0]    o_hclk_ff, o_hclk_in;
   logic [RateWidth-1:0]    o_pclk_ff, o_pclk_in;
   logic [RateWidth-1:0]    o_core_ff, o_core_in;
   logic                    o_pwm_ff, o_pwm_in;
   err_type                 o_err_ff, o_err_in;
   logic                    o_chg_ff, o_chg_in;
   logic                    o_idle_ff, o_idle_in;
   logic                    o_sleep_ff, o_sleep_in;

   // Request decode.
   logic                    accept;
   logic                    off_ok;
   logic [SlotWidth-1:0]    slot;
   logic [DataWidth-1:0]    wdata;
   logic                    out_free;

   // Derivation operands.
   logic [DataWidth-1:0]    mpll, slow, divn;
   logic [8:0]              pll_m;
   logic [6:0]              pll_p;
   logic [ProdWidth-1:0]    product;
   logic [DivisorWidth:0]   rem_shift;
   logic                    rem_ge;
   logic [RateWidth-1:0]    quot;

   assign accept = req_ch.valid && req_ch.ready;
   assign off_ok = (req_ch.byte_offset[1:0] == 2'b00)
                && (req_ch.byte_offset[OffsetWidth-1:2] < (OffsetWidth-2)'(RegCount));
   assign slot   = req_ch.byte_offset[SlotWidth+1:2];
   assign wdata  = req_ch.write_data;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   // Operands of the fast clock derivation; the product is registered into the divider.
   assign mpll    = regs_ff[SlotMpllcon];
   assign slow    = regs_ff[SlotClkslow];
   assign divn    = regs_ff[SlotClkdivn];
   assign pll_m   = {1'b0, mpll[19:12]} + 9'd8;
   assign pll_p   = {1'b0, mpll[9:4]} + 7'd2;
   assign product = ProdWidth'(pll_m) * ProdWidth'(fin_ff);

   // One restoring division step.
   assign rem_shift = {rem_ff, quo_ff[ProdWidth-1]};
   assign rem_ge    = (rem_shift >= {1'b0, dvs_ff});
   assign quot      = quo_ff[RateWidth-1:0];

   // Sequencer, register file update and response assembly.
   always_comb begin
      state_in     = state_ff;
      regs_in      = regs_ff;
      pll_set_in   = pll_set_ff;
      fclk_in      = fclk_ff;
      hclk_in      = hclk_ff;
      pclk_in      = pclk_ff;
      rd_in        = rd_ff;
      err_in       = err_ff;
      chg_in       = chg_ff;
      idle_in      = idle_ff;
      sleep_in     = sleep_ff;
      mode_in      = mode_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_rd_in      = o_rd_ff;
      o_fclk_in    = o_fclk_ff;
      o_hclk_in    = o_hclk_ff;
      o_pclk_in    = o_pclk_ff;
      o_core_in    = o_core_ff;
      o_pwm_in     = o_pwm_ff;
      o_err_in     = o_err_ff;
      o_chg_in     = o_chg_ff;
      o_idle_in    = o_idle_ff;
      o_sleep_in   = o_sleep_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rd_in    = '0;
               err_in   = ERR_OK;
               chg_in   = 1'b0;
               idle_in  = 1'b0;
               sleep_in = 1'b0;
               mode_in  = req_ch.bus_mode_bits;
               state_in = ST_REPLY;
               unique case (kind_type'(req_ch.kind))
                  KIND_READ: begin
                     if (!off_ok) begin
                        err_in = ERR_BAD_OFFSET;
                     end else begin
                        rd_in = regs_ff[slot];
                        if (slot == SlotLocktime || slot == SlotUpllcon) begin
                           err_in = ERR_UNMODELED;
                        end
                     end
                  end
                  KIND_WRITE: begin
                     if (!off_ok) begin
                        err_in = ERR_BAD_OFFSET;
                     end else begin
                        regs_in[slot] = wdata;
                        priority if (slot == SlotMpllcon) begin
                           pll_set_in = 1'b1;
                           chg_in     = 1'b1;
                           state_in   = ST_LOAD;
                        end else if (slot == SlotClkslow) begin
                           priority if (wdata[SlowMpllOff]) begin
                              err_in = ERR_MPLL_OFF;
                           end else if (wdata[SlowUclkOn]) begin
                              err_in = ERR_UCLK_OFF;
                           end else begin
                              chg_in   = 1'b1;
                              state_in = ST_LOAD;
                           end
                        end else if (slot == SlotClkdivn) begin
                           chg_in   = 1'b1;
                           state_in = ST_LOAD;
                        end else if (slot == SlotClkcon) begin
                           priority if (wdata[ClkconIdle] && wdata[ClkconPwrOff]) begin
                              err_in = ERR_IDLE_POWER;
                           end else if (wdata[ClkconSpecial]) begin
                              err_in = ERR_SPECIAL;
                           end else if ((~wdata & ClkconGateMask) != '0) begin
                              err_in = ERR_GATES;
                           end else begin
                              chg_in   = 1'b1;
                              sleep_in = wdata[ClkconPwrOff];
                              idle_in  = !wdata[ClkconPwrOff] && wdata[ClkconIdle];
                           end
                        end else begin
                           // Lock time and USB PLL writes are only stored.
                           err_in = ERR_OK;
                        end
                     end
                  end
                  KIND_RESET: begin
                     for (int i = 0; i < RegCount; i++) begin
                        regs_in[i] = reg_reset(SlotWidth'(i));
                     end
                     pll_set_in = 1'b0;
                     state_in   = ST_LOAD;
                  end
                  KIND_REFRESH: begin
                     chg_in   = 1'b1;
                     state_in = ST_LOAD;
                  end
                  default: state_in = ST_REPLY;
               endcase
            end
         end

         // Select dividend and divisor for the fast clock.
         ST_LOAD: begin
            rem_in = '0;
            cnt_in = '0;
            priority if (slow[SlowModeBit] && slow[2:0] != 3'd0) begin
               quo_in = ProdWidth'(fin_ff);
               dvs_in = {6'd0, slow[2:0], 1'b0};
            end else if (!slow[SlowModeBit] && pll_set_ff) begin
               quo_in = product;
               dvs_in = DivisorWidth'({3'd0, pll_p} << mpll[1:0]);
            end else begin
               quo_in = ProdWidth'(fin_ff);
               dvs_in = DivisorWidth'(1);
            end
            state_in = ST_DIV;
         end

         // Shared divider: one quotient bit per cycle.
         ST_DIV: begin
            rem_in = rem_ge ? DivisorWidth'(rem_shift - {1'b0, dvs_ff})
                            : rem_shift[DivisorWidth-1:0];
            quo_in = {quo_ff[ProdWidth-2:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CountWidth'(ProdWidth-1)) begin
               state_in = ST_RATES;
            end
         end

         // Bus and peripheral clocks follow from the divider bits.
         ST_RATES: begin
            fclk_in = quot;
            if (divn[2]) begin
               hclk_in = quot >> 2;
               pclk_in = quot >> 2;
            end else begin
               hclk_in = divn[1] ? (quot >> 1) : quot;
               pclk_in = divn[0] ? (hclk_in >> 1) : hclk_in;
            end
            state_in = ST_REPLY;
         end

         // Load the response register once it is free.
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_rd_in      = rd_ff;
               o_fclk_in    = fclk_ff;
               o_hclk_in    = hclk_ff;
               o_pclk_in    = pclk_ff;
               o_core_in    = (mode_ff == 2'b00) ? hclk_ff : fclk_ff;
               o_pwm_in     = regs_ff[SlotClkcon][ClkconPwm];
               o_err_in     = err_ff;
               o_chg_in     = chg_ff;
               o_idle_in    = idle_ff;
               o_sleep_in   = sleep_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State register of the sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCount; i++) begin
            regs_ff[i] <= reg_reset(SlotWidth'(i));
         end
         pll_set_ff   <= 1'b0;
         fin_ff       <= InputClockReset;
         fclk_ff      <= RateReset;
         hclk_ff      <= RateReset;
         pclk_ff      <= RateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         regs_ff      <= regs_in;
         pll_set_ff   <= pll_set_in;
         fclk_ff      <= fclk_in;
         hclk_ff      <= hclk_in;
         pclk_ff      <= pclk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            fin_ff <= csr_ch.input_clock_hz;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_ff      <= rd_in;
      err_ff     <= err_in;
      chg_ff     <= chg_in;
      idle_ff    <= idle_in;
      sleep_ff   <= sleep_in;
      mode_ff    <= mode_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      o_rd_ff    <= o_rd_in;
      o_fclk_ff  <= o_fclk_in;
      o_hclk_ff  <= o_hclk_in;
      o_pclk_ff  <= o_pclk_in;
      o_core_ff  <= o_core_in;
      o_pwm_ff   <= o_pwm_in;
      o_err_ff   <= o_err_in;
      o_chg_ff   <= o_chg_in;
      o_idle_ff  <= o_idle_in;
      o_sleep_ff <= o_sleep_in;
   end

   // Response channel.
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.read_data       = o_rd_ff;
   assign rsp_ch.fast_clock_hz   = o_fclk_ff;
   assign rsp_ch.bus_clock_hz    = o_hclk_ff;
   assign rsp_ch.periph_clock_hz = o_pclk_ff;
   assign rsp_ch.core_clock_hz   = o_core_ff;
   assign rsp_ch.pwm_clock_on    = o_pwm_ff;
   assign rsp_ch.error_code      = o_err_ff;
   assign rsp_ch.rates_changed   = o_chg_ff;
   assign rsp_ch.idle_request    = o_idle_ff;
   assign rsp_ch.sleep_request   = o_sleep_ff;

`ifndef ASSERT_OFF
   // An accepted transfer always moves the sequencer out of idle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after an accepted transfer");

   // The divider never runs with a zero divisor.
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> dvs_ff != '0)
      else $error("divider running with zero divisor");

   // A flagged error never comes with a notification or a request.
   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && o_err_ff != ERR_OK |-> !o_chg_ff && !o_idle_ff && !o_sleep_ff)
      else $error("error response carries a side action");

   // Idle and sleep requests exclude each other.
   a_idle_sleep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(o_idle_ff && o_sleep_ff))
      else $error("idle and sleep requested together");
`endif

endmodule

`default_nettype wire
